// ===== hw/rtl/ufe_pkg.sv =====
// ----------------------------------------------------------------------------
// ufe_pkg: shared types, constants and microcode for the union-find engine
// Step numbers, datapath actions, jump conditions and the control store.
// ----------------------------------------------------------------------------
package ufe_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int ELEM_W       = 10;
  localparam int SIZE_W       = 11;
  localparam int PC_W         = 4;

  localparam logic [PC_W-1:0] STEP_CLR      = 4'd0;
  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd1;
  localparam logic [PC_W-1:0] STEP_RANGE    = 4'd2;
  localparam logic [PC_W-1:0] STEP_FA_CHK   = 4'd3;
  localparam logic [PC_W-1:0] STEP_FA_HALF  = 4'd4;
  localparam logic [PC_W-1:0] STEP_FB_START = 4'd5;
  localparam logic [PC_W-1:0] STEP_FB_CHK   = 4'd6;
  localparam logic [PC_W-1:0] STEP_FB_HALF  = 4'd7;
  localparam logic [PC_W-1:0] STEP_DECIDE   = 4'd8;
  localparam logic [PC_W-1:0] STEP_SZ_A     = 4'd9;
  localparam logic [PC_W-1:0] STEP_MERGE    = 4'd10;
  localparam logic [PC_W-1:0] STEP_DONE     = 4'd11;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_CLEAR,
    ACT_LOAD,
    ACT_RD_NODE,
    ACT_CHK,
    ACT_HALF,
    ACT_SAVE_A,
    ACT_SAVE_B,
    ACT_RD_SB,
    ACT_MERGE,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_WAIT_IN,
    COND_BAD,
    COND_ROOT,
    COND_NOMERGE,
    COND_CLR_BUSY
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic is_root;
    logic bad;
    logic no_merge;
    logic clr_last;
  } status_t;

  function automatic uword_t ufe_ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_CLR:      w = '{ACT_CLEAR,   COND_CLR_BUSY, STEP_CLR};
      STEP_IDLE:     w = '{ACT_LOAD,    COND_WAIT_IN,  STEP_IDLE};
      STEP_RANGE:    w = '{ACT_RD_NODE, COND_BAD,      STEP_DONE};
      STEP_FA_CHK:   w = '{ACT_CHK,     COND_ROOT,     STEP_FB_START};
      STEP_FA_HALF:  w = '{ACT_HALF,    COND_ALWAYS,   STEP_FA_CHK};
      STEP_FB_START: w = '{ACT_SAVE_A,  COND_NONE,     STEP_IDLE};
      STEP_FB_CHK:   w = '{ACT_CHK,     COND_ROOT,     STEP_DECIDE};
      STEP_FB_HALF:  w = '{ACT_HALF,    COND_ALWAYS,   STEP_FB_CHK};
      STEP_DECIDE:   w = '{ACT_SAVE_B,  COND_NOMERGE,  STEP_DONE};
      STEP_SZ_A:     w = '{ACT_RD_SB,   COND_NONE,     STEP_IDLE};
      STEP_MERGE:    w = '{ACT_MERGE,   COND_NONE,     STEP_IDLE};
      STEP_DONE:     w = '{ACT_EMIT,    COND_ALWAYS,   STEP_IDLE};
      default:       w = '{ACT_NOP,     COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/union_find_engine.sv =====
// ----------------------------------------------------------------------------
// union_find_engine: disjoint-set engine, union by size with path halving
// Requests on the in_ stream are queries or merges over 1024 elements; each
// request yields one answer bit on the out_ stream.
//
// in_tuser[0] is the opcode (0 query, 1 merge); in_tdata carries the two
// element indices. out_tdata[0] is the answer: same set for a query, sets
// joined for a merge.
// One request is processed at a time by a microcoded sequencer driving a
// parent table and a size table, each with one read and one write port. A
// query on two roots goes from accept through the range read, the root
// checks of a and b and the decide and emit steps to out_tvalid; each path
// halving step adds a parent read and write, and a merge of distinct sets
// adds the size reads and the merge step. After reset a clearing pass over
// all 1024 entries initializes both tables; in_tready stays low during it.
// A result waiting in the output register holds in_tready low; once it is
// taken, the next request can be accepted in that same cycle.
// ----------------------------------------------------------------------------
module union_find_engine import ufe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] elem_a, [19:10] elem_b, [23:20] zero
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] answer, [7:1] zero
);

  act_t    act;
  status_t status;
  logic    in_acc;
  logic    answer;

  assign in_tready = (act == ACT_LOAD) && (!out_tvalid || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tdata = {7'd0, answer};

  ufe_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_acc (in_acc),
    .status (status),
    .act    (act)
  );

  ufe_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .act        (act),
    .in_opcode  (in_tuser[0]),
    .in_elem_a  (in_tdata[9:0]),
    .in_elem_b  (in_tdata[19:10]),
    .out_ready  (out_tready),
    .status     (status),
    .out_valid  (out_tvalid),
    .out_answer (answer)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("engine still ready after accepting a request");

  a_slot_free_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result slot occupied while a request is in flight");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("engine ready before the table clearing pass");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("nonzero padding on result");

endmodule

// ===== hw/rtl/ufe_sequencer.sv =====
// ----------------------------------------------------------------------------
// ufe_sequencer: step counter and control store
// Fetches one control word per cycle and branches on datapath status or on request acceptance.
// ----------------------------------------------------------------------------
module ufe_sequencer import ufe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_acc,
  input  status_t status,
  output act_t    act
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uword_t          uw;
  logic            taken;

  assign uw  = ufe_ucode(pc_r);
  assign act = uw.act;

  always_comb begin
    case (uw.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_WAIT_IN:  taken = !in_acc;
      COND_BAD:      taken = status.bad;
      COND_ROOT:     taken = status.is_root;
      COND_NOMERGE:  taken = status.no_merge;
      COND_CLR_BUSY: taken = !status.clr_last;
      default:       taken = 1'b1;
    endcase
    pc_nxt = taken ? uw.tgt : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hw/rtl/ufe_datapath.sv =====
// ----------------------------------------------------------------------------
// ufe_datapath: parent and size tables with working registers
// Executes one action per cycle as directed by the sequencer.
// ----------------------------------------------------------------------------
module ufe_datapath import ufe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  act_t              act,
  input  logic              in_opcode,
  input  logic [ELEM_W-1:0] in_elem_a,
  input  logic [ELEM_W-1:0] in_elem_b,
  input  logic              out_ready,
  output status_t           status,
  output logic              out_valid,
  output logic              out_answer
);

  localparam logic [ELEM_W:0] NUM_EL = (ELEM_W+1)'(NUM_ELEMENTS);
  localparam logic [ELEM_W-1:0] LAST_EL = ELEM_W'(NUM_ELEMENTS - 1);

  logic [ELEM_W-1:0] parent_mem [NUM_ELEMENTS];
  logic [SIZE_W-1:0] size_mem   [NUM_ELEMENTS];

  logic [ELEM_W-1:0] p_rdata_r;
  logic [SIZE_W-1:0] s_rdata_r;
  logic [ELEM_W-1:0] clr_cnt_r;
  logic              op_r;
  logic [ELEM_W-1:0] elem_a_r;
  logic [ELEM_W-1:0] elem_b_r;
  logic [ELEM_W-1:0] node_r;
  logic [ELEM_W-1:0] ra_r;
  logic [ELEM_W-1:0] rb_r;
  logic [SIZE_W-1:0] sz_a_r;
  logic              ans_r;
  logic              out_valid_r;
  logic              out_answer_r;

  logic              p_we;
  logic [ELEM_W-1:0] p_waddr;
  logic [ELEM_W-1:0] p_wdata;
  logic [ELEM_W-1:0] p_raddr;
  logic              s_we;
  logic [ELEM_W-1:0] s_waddr;
  logic [SIZE_W-1:0] s_wdata;
  logic [ELEM_W-1:0] s_raddr;
  logic              big_is_b;
  logic [SIZE_W-1:0] sz_sum;

  assign big_is_b = sz_a_r < s_rdata_r;
  assign sz_sum   = sz_a_r + s_rdata_r;

  assign status.is_root  = (p_rdata_r == node_r);
  assign status.bad      = ({1'b0, elem_a_r} >= NUM_EL) || ({1'b0, elem_b_r} >= NUM_EL);
  assign status.no_merge = !op_r || (ra_r == node_r);
  assign status.clr_last = (clr_cnt_r == LAST_EL);

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = node_r;
    p_wdata = p_rdata_r;
    p_raddr = node_r;
    s_we    = 1'b0;
    s_waddr = ra_r;
    s_wdata = sz_sum;
    s_raddr = ra_r;
    case (act)
      ACT_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_cnt_r;
        p_wdata = clr_cnt_r;
        s_we    = 1'b1;
        s_waddr = clr_cnt_r;
        s_wdata = SIZE_W'(1);
      end
      ACT_CHK: begin
        p_raddr = p_rdata_r;
      end
      ACT_HALF: begin
        p_we    = 1'b1;
        p_raddr = p_rdata_r;
      end
      ACT_SAVE_A: begin
        p_raddr = elem_b_r;
      end
      ACT_RD_SB: begin
        s_raddr = rb_r;
      end
      ACT_MERGE: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        p_waddr = big_is_b ? ra_r : rb_r;
        p_wdata = big_is_b ? rb_r : ra_r;
        s_waddr = big_is_b ? rb_r : ra_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
    s_rdata_r <= size_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    case (act)
      ACT_LOAD: begin
        op_r     <= in_opcode;
        elem_a_r <= in_elem_a;
        elem_b_r <= in_elem_b;
        node_r   <= in_elem_a;
        ans_r    <= 1'b0;
      end
      ACT_HALF: begin
        node_r <= p_rdata_r;
      end
      ACT_SAVE_A: begin
        ra_r   <= node_r;
        node_r <= elem_b_r;
      end
      ACT_SAVE_B: begin
        rb_r  <= node_r;
        ans_r <= !op_r && (ra_r == node_r);
      end
      ACT_RD_SB: begin
        sz_a_r <= s_rdata_r;
      end
      ACT_MERGE: begin
        ans_r <= 1'b1;
      end
      ACT_EMIT: begin
        out_answer_r <= ans_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (act == ACT_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (act == ACT_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/tb_union_find_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_union_find_engine: self-checking bench for the disjoint-set engine
// Streams query and merge requests into the engine, keeps its own copy of the
// parent and size tables with union by size and path halving, and compares
// every answer bit in order. The sender idles in bursts, the receiver stalls
// on its own pattern, and one long receiver hold backs the engine up.
// ----------------------------------------------------------------------------
module tb_union_find_engine;
  import ufe_pkg::*;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  localparam int RANDOM_REQUESTS = 1160;
  localparam int HOLD_CYCLES     = 400;

  typedef struct {
    logic              op;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic              answer;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [9:0] elem_a, [19:10] elem_b, [23:20] zero
  logic [0:0]  in_tuser;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] answer, [7:1] zero

  logic [ELEM_W-1:0] parent_of [NUM_ELEMENTS];
  logic [SIZE_W-1:0] set_size  [NUM_ELEMENTS];
  answer_t           pending_answers [$];

  int mismatch_count = 0;
  int burst_left     = 0;
  bit tx_idle_en     = 1'b1;
  bit rx_always      = 1'b0;
  bit hold_request   = 1'b0;

  union_find_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_sets();
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      parent_of[i] = ELEM_W'(i);
      set_size[i]  = SIZE_W'(1);
    end
  endfunction

  // path halving: each visited node jumps to its grandparent
  function automatic logic [ELEM_W-1:0] find_root(input logic [ELEM_W-1:0] node);
    logic [ELEM_W-1:0] n;
    n = node;
    while (parent_of[n] != n) begin
      parent_of[n] = parent_of[parent_of[n]];
      n = parent_of[n];
    end
    return n;
  endfunction

  function automatic logic predict_answer(input logic op, input logic [ELEM_W-1:0] a,
                                          input logic [ELEM_W-1:0] b);
    logic [ELEM_W-1:0] ra, rb, t;
    ra = find_root(a);
    rb = find_root(b);
    if (op == OP_QUERY) return ra == rb;
    if (ra == rb) return 1'b0;
    if (set_size[ra] < set_size[rb]) begin
      t  = ra;
      ra = rb;
      rb = t;
    end
    set_size[ra]  = set_size[ra] + set_size[rb];
    parent_of[rb] = ra;
    return 1'b1;
  endfunction

  task automatic send_request(input logic op, input logic [ELEM_W-1:0] a,
                              input logic [ELEM_W-1:0] b);
    int gap;
    answer_t exp_item;
    if (burst_left == 0) begin
      gap        = tx_idle_en ? $urandom_range(0, 8) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    exp_item.op     = op;
    exp_item.a      = a;
    exp_item.b      = b;
    exp_item.answer = predict_answer(op, a, b);
    pending_answers.insert(pending_answers.size(), exp_item);
  endtask

  // receiver: alternating ready/stall runs or always ready, plus an optional long hold
  initial begin
    int  run_left;
    bit  ready_phase;
    run_left    = 0;
    ready_phase = 1'b0;
    out_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (run_left == 0) begin
          ready_phase = !ready_phase;
          run_left    = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        run_left--;
        out_tready <= rx_always ? 1'b1 : ready_phase;
      end
    end
  end

  always @(posedge clk) begin
    answer_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("answer arrived with no request outstanding: actual %0d", out_tdata[0]);
        mismatch_count++;
      end else begin
        exp_item = pending_answers.pop_front();
        if (out_tdata[0] !== exp_item.answer) begin
          $error("answer mismatch (op %0d a %0d b %0d): expected %0d, actual %0d",
                 exp_item.op, exp_item.a, exp_item.b, exp_item.answer, out_tdata[0]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_trivial_sets();
    send_request(OP_QUERY, 10'd0, 10'd0);
    send_request(OP_QUERY, 10'd0, 10'd1023);
    send_request(OP_MERGE, 10'd5, 10'd5);
  endtask

  task automatic test_size_ordering();
    send_request(OP_MERGE, 10'd0, 10'd1023);    // equal sizes, keep a's root
    send_request(OP_MERGE, 10'd1023, 10'd512);  // a's set larger
    send_request(OP_MERGE, 10'd7, 10'd0);       // b's set larger, swap
    send_request(OP_QUERY, 10'd7, 10'd1023);
    send_request(OP_MERGE, 10'd1023, 10'd7);    // already one set
  endtask

  task automatic test_deep_tree();
    for (int step = 1; step < 16; step *= 2)
      for (int i = 0; i < 16; i += 2 * step)
        send_request(OP_MERGE, ELEM_W'(100 + i), ELEM_W'(100 + i + step));
    send_request(OP_QUERY, 10'd115, 10'd100);
    send_request(OP_QUERY, 10'd115, 10'd113);
  endtask

  task automatic test_random_mix();
    logic [ELEM_W-1:0] a, b;
    logic              op;
    int                base;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_always  = $urandom_range(0, 3) == 0;
      end
      if ($urandom_range(0, 9) < 7) begin
        base = $urandom_range(0, 15) * 64;
        a    = ELEM_W'(base + $urandom_range(0, 63));
        b    = ELEM_W'(base + $urandom_range(0, 63));
      end else begin
        a = ELEM_W'($urandom_range(0, NUM_ELEMENTS - 1));
        b = ELEM_W'($urandom_range(0, NUM_ELEMENTS - 1));
      end
      if ($urandom_range(0, 19) == 0) b = a;
      op = ($urandom_range(0, 19) < 11) ? OP_MERGE : OP_QUERY;
      send_request(op, a, b);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    rx_always    = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 20; n++)
      send_request(n[0] ? OP_MERGE : OP_QUERY, ELEM_W'($urandom_range(0, 1023)),
                   ELEM_W'($urandom_range(0, 1023)));
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    clear_sets();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_trivial_sets();
    test_size_ordering();
    test_deep_tree();
    test_random_mix();
    test_backpressure();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ufe_pkg.sv
hw/rtl/ufe_sequencer.sv
hw/rtl/ufe_datapath.sv
hw/rtl/union_find_engine.sv
dv/tb_union_find_engine.sv
